FILE: rtl/svm_pkg.sv
`timescale 1ns / 1ps
package svm_pkg;

  localparam logic [5:0] OP_LEA  = 6'd0;
  localparam logic [5:0] OP_IMM  = 6'd1;
  localparam logic [5:0] OP_JMP  = 6'd2;
  localparam logic [5:0] OP_CALL = 6'd3;
  localparam logic [5:0] OP_JZ   = 6'd4;
  localparam logic [5:0] OP_JNZ  = 6'd5;
  localparam logic [5:0] OP_ENT  = 6'd6;
  localparam logic [5:0] OP_ADJ  = 6'd7;
  localparam logic [5:0] OP_LEV  = 6'd8;
  localparam logic [5:0] OP_LI   = 6'd9;
  localparam logic [5:0] OP_LC   = 6'd10;
  localparam logic [5:0] OP_SI   = 6'd11;
  localparam logic [5:0] OP_SC   = 6'd12;
  localparam logic [5:0] OP_PUSH = 6'd13;
  localparam logic [5:0] OP_OR   = 6'd14;
  localparam logic [5:0] OP_XOR  = 6'd15;
  localparam logic [5:0] OP_AND  = 6'd16;
  localparam logic [5:0] OP_EQ   = 6'd17;
  localparam logic [5:0] OP_NE   = 6'd18;
  localparam logic [5:0] OP_LT   = 6'd19;
  localparam logic [5:0] OP_GT   = 6'd20;
  localparam logic [5:0] OP_LE   = 6'd21;
  localparam logic [5:0] OP_GE   = 6'd22;
  localparam logic [5:0] OP_SHL  = 6'd23;
  localparam logic [5:0] OP_SHR  = 6'd24;
  localparam logic [5:0] OP_ADD  = 6'd25;
  localparam logic [5:0] OP_SUB  = 6'd26;
  localparam logic [5:0] OP_MUL  = 6'd27;
  localparam logic [5:0] OP_DIV  = 6'd28;
  localparam logic [5:0] OP_MOD  = 6'd29;
  localparam logic [5:0] OP_PRTF = 6'd33;
  localparam logic [5:0] OP_EXIT = 6'd37;

  localparam logic [2:0] ST_RUN   = 3'd0;
  localparam logic [2:0] ST_EXIT  = 3'd1;
  localparam logic [2:0] ST_BADOP = 3'd2;
  localparam logic [2:0] ST_DIV0  = 3'd3;
  localparam logic [2:0] ST_ADDR  = 3'd4;

  localparam logic [5:0] MD_MUL_LAST = 6'd3;
  localparam logic [5:0] MD_DIV_LAST = 6'd63;

  typedef enum logic [1:0] {
    MD_MUL,
    MD_DIV,
    MD_MOD
  } md_op_e;

  typedef struct packed {
    logic        start;
    md_op_e      op;
    logic [63:0] x;
    logic [63:0] y;
  } md_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] result;
  } md_rsp_t;

  function automatic logic [63:0] sext8(logic [63:0] v);
    return {{56{v[7]}}, v[7:0]};
  endfunction

endpackage

FILE: rtl/svm_ram.sv
`timescale 1ns / 1ps
module svm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32768
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [WIDTH-1:0]         wmask_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      for (int i = 0; i < WIDTH; i++) begin
        if (wmask_i[i]) begin
          mem_q[waddr_i][i] <= wdata_i[i];
        end
      end
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/svm_muldiv.sv
`timescale 1ns / 1ps
module svm_muldiv
  import svm_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  md_req_t req_i,
  output md_rsp_t rsp_o
);

  logic        busy_q, done_q, neg_q;
  md_op_e      kind_q;
  logic [5:0]  cnt_q;
  logic [63:0] acc_q, sh_q, den_q;
  logic [63:0] ux, uy, pp, rs;
  logic        nx, ny, last;

  assign nx   = req_i.x[63];
  assign ny   = req_i.y[63];
  assign ux   = nx ? 64'd0 - req_i.x : req_i.x;
  assign uy   = ny ? 64'd0 - req_i.y : req_i.y;
  assign pp   = 64'(den_q * sh_q[15:0]);
  assign rs   = {acc_q[62:0], sh_q[63]};
  assign last = (kind_q == MD_MUL) ? (cnt_q == MD_MUL_LAST) : (cnt_q == MD_DIV_LAST);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q && last) begin
      busy_q <= 1'b0;
      done_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      kind_q <= req_i.op;
      cnt_q  <= '0;
      if (req_i.op == MD_MUL) begin
        acc_q <= '0;
        den_q <= req_i.x;
        sh_q  <= req_i.y;
        neg_q <= 1'b0;
      end else begin
        acc_q <= '0;
        den_q <= uy;
        sh_q  <= ux;
        neg_q <= (req_i.op == MD_DIV) ? (nx ^ ny) : nx;
      end
    end else if (busy_q) begin
      cnt_q <= cnt_q + 6'd1;
      if (kind_q == MD_MUL) begin
        acc_q <= acc_q + pp;
        den_q <= {den_q[47:0], 16'd0};
        sh_q  <= {16'd0, sh_q[63:16]};
      end else if (rs >= den_q) begin
        acc_q <= rs - den_q;
        sh_q  <= {sh_q[62:0], 1'b1};
      end else begin
        acc_q <= rs;
        sh_q  <= {sh_q[62:0], 1'b0};
      end
    end
  end

  always_comb begin
    rsp_o.done = done_q;
    case (kind_q)
      MD_MUL:  rsp_o.result = acc_q;
      MD_DIV:  rsp_o.result = neg_q ? 64'd0 - sh_q : sh_q;
      default: rsp_o.result = neg_q ? 64'd0 - acc_q : acc_q;
    endcase
  end

endmodule

FILE: rtl/stack_vm_execute_unit.sv
`timescale 1ns / 1ps
// Most requests go through accept, then read-execute-write on the data RAM (S_EXEC).
// LEV goes on to S_LEV: its two stack words come through the single RAM read port.
// MUL, DIV and MOD wait in S_MD: a 64x16 multiply step or one quotient bit per cycle.
// One request in flight; a result may wait in the output register while the next is taken.
// Reset: acc 0, pc 0, sp and fp at MEM_WORDS*8, not halted; data RAM is not cleared.
module stack_vm_execute_unit
  import svm_pkg::*;
#(
  parameter int MEM_WORDS  = 32768,
  parameter int TEXT_WORDS = 32768
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [5:0]         action_i,
  input  logic signed [63:0] operand_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [63:0] acc_value_o,
  output logic [14:0]        next_pc_o,
  output logic               print_strobe_o,
  output logic [2:0]         status_o
);

  localparam int AW  = $clog2(MEM_WORDS);
  localparam int SW  = $clog2(MEM_WORDS * 8 + 1);
  localparam int PCW = $clog2(TEXT_WORDS);
  localparam logic [63:0] MEM_BYTES = 64'(MEM_WORDS) << 3;
  localparam logic [63:0] TEXT_LIM  = 64'(TEXT_WORDS);
  localparam logic [63:0] OFS_LIM   = 64'(MEM_WORDS) << 1;

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_LEV, S_MD} state_e;

  state_e          state_q;
  logic [5:0]      op_q;
  logic [63:0]     opd_q, t_q, acc_q;
  logic [SW-1:0]   sp_q, bp_q;
  logic [PCW-1:0]  pc_q;
  logic            halted_q;
  logic [2:0]      code_q;
  logic            out_valid_q, out_strobe_q;
  logic [63:0]     out_acc_q;
  logic [14:0]     out_pc_q;
  logic [2:0]      out_status_q;

  logic [63:0] sp64, bp64, pc64, rd_data, x, a_n, sp_n, bp_n, npc, sp_m8;
  logic [63:0] waddr, wdata, wmask, raddr, ofs8;
  logic [2:0]  err;
  logic        exit_n, strobe, wr, wbyte, pop, push_ok, ofs_ok, lev_addr_err;
  logic        need_md, accept, out_free, commit, halt_now, re;
  md_req_t     md_req;
  md_rsp_t     md_rsp;

  function automatic logic word_ok(logic [63:0] v);
    return (v[2:0] == 3'b000) && (v <= MEM_BYTES - 64'd8);
  endfunction

  assign sp64     = 64'(sp_q);
  assign bp64     = 64'(bp_q);
  assign pc64     = 64'(pc_q);
  assign sp_m8    = sp64 - 64'd8;
  assign ofs8     = {opd_q[60:0], 3'b000};
  assign push_ok  = (sp64 >= 64'd8) && word_ok(sp_m8);
  assign ofs_ok   = (opd_q + 64'(MEM_WORDS)) <= OFS_LIM;
  assign lev_addr_err = !word_ok(bp64) || !word_ok(bp64 + 64'd8);
  assign pop      = (op_q inside {[OP_OR:OP_MOD], OP_SI, OP_SC});
  assign x        = rd_data;

  always_comb begin
    a_n    = acc_q;
    sp_n   = sp64;
    bp_n   = bp64;
    npc    = pc64 + 64'd1;
    err    = ST_RUN;
    exit_n = 1'b0;
    strobe = 1'b0;
    wr     = 1'b0;
    wbyte  = 1'b0;
    waddr  = '0;
    wdata  = '0;
    if (pop) begin
      if (!word_ok(sp64)) err = ST_ADDR;
      else sp_n = sp64 + 64'd8;
    end
    if (err == ST_RUN) begin
      case (op_q)
        OP_LEA: begin
          a_n = bp64 + ofs8;
          npc = pc64 + 64'd2;
        end
        OP_IMM: begin
          a_n = opd_q;
          npc = pc64 + 64'd2;
        end
        OP_JMP: npc = opd_q;
        OP_CALL: begin
          if (!push_ok) err = ST_ADDR;
          else begin
            sp_n  = sp_m8;
            wr    = 1'b1;
            waddr = sp_m8;
            wdata = pc64 + 64'd2;
            npc   = opd_q;
          end
        end
        OP_JZ:  npc = (acc_q != 64'd0) ? pc64 + 64'd2 : opd_q;
        OP_JNZ: npc = (acc_q != 64'd0) ? opd_q : pc64 + 64'd2;
        OP_ENT: begin
          if (!push_ok || !ofs_ok) err = ST_ADDR;
          else begin
            wr    = 1'b1;
            waddr = sp_m8;
            wdata = bp64;
            bp_n  = sp_m8;
            sp_n  = sp_m8 - ofs8;
            if (sp_n > MEM_BYTES) err = ST_ADDR;
            npc = pc64 + 64'd2;
          end
        end
        OP_ADJ: begin
          if (!ofs_ok) err = ST_ADDR;
          else begin
            sp_n = sp64 + ofs8;
            if (sp_n > MEM_BYTES) err = ST_ADDR;
            npc = pc64 + 64'd2;
          end
        end
        OP_LEV: begin
          if (lev_addr_err) err = ST_ADDR;
          else begin
            sp_n = bp64 + 64'd16;
            npc  = rd_data;
            bp_n = t_q;
            if ((t_q[2:0] != 3'b000) || (t_q > MEM_BYTES)) err = ST_ADDR;
          end
        end
        OP_LI: begin
          if (!word_ok(acc_q)) err = ST_ADDR;
          else a_n = rd_data;
        end
        OP_LC: begin
          if (acc_q >= MEM_BYTES) err = ST_ADDR;
          else a_n = sext8(rd_data >> {acc_q[2:0], 3'b000});
        end
        OP_SI: begin
          if (!word_ok(x)) err = ST_ADDR;
          else begin
            wr    = 1'b1;
            waddr = x;
            wdata = acc_q;
          end
        end
        OP_SC: begin
          if (x >= MEM_BYTES) err = ST_ADDR;
          else begin
            wr    = 1'b1;
            wbyte = 1'b1;
            waddr = x;
            wdata = 64'(acc_q[7:0]) << {x[2:0], 3'b000};
            a_n   = sext8(acc_q);
          end
        end
        OP_PUSH: begin
          if (!push_ok) err = ST_ADDR;
          else begin
            sp_n  = sp_m8;
            wr    = 1'b1;
            waddr = sp_m8;
            wdata = acc_q;
          end
        end
        OP_OR:  a_n = x | acc_q;
        OP_XOR: a_n = x ^ acc_q;
        OP_AND: a_n = x & acc_q;
        OP_EQ:  a_n = 64'(x == acc_q);
        OP_NE:  a_n = 64'(x != acc_q);
        OP_LT:  a_n = 64'($signed(x) < $signed(acc_q));
        OP_GT:  a_n = 64'($signed(acc_q) < $signed(x));
        OP_LE:  a_n = 64'(!($signed(acc_q) < $signed(x)));
        OP_GE:  a_n = 64'(!($signed(x) < $signed(acc_q)));
        OP_SHL: a_n = (acc_q >= 64'd64) ? 64'd0 : x << acc_q[5:0];
        OP_SHR: a_n = (acc_q >= 64'd64) ? {64{x[63]}} : 64'($signed(x) >>> acc_q[5:0]);
        OP_ADD: a_n = x + acc_q;
        OP_SUB: a_n = x - acc_q;
        OP_MUL: a_n = md_rsp.result;
        OP_DIV, OP_MOD: begin
          if (acc_q == 64'd0) err = ST_DIV0;
          else a_n = md_rsp.result;
        end
        OP_PRTF: strobe = 1'b1;
        OP_EXIT: exit_n = 1'b1;
        default: err = ST_BADOP;
      endcase
    end
    if ((err == ST_RUN) && !exit_n && (npc >= TEXT_LIM)) err = ST_ADDR;
  end

  assign halt_now = (err != ST_RUN) || exit_n;
  assign need_md  = (op_q inside {[OP_MUL:OP_MOD]}) && (err == ST_RUN);
  assign accept   = in_valid_i && (state_q == S_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    commit = 1'b0;
    case (state_q)
      S_EXEC:  commit = out_free && (halted_q ||
                 (!need_md && !((op_q == OP_LEV) && !lev_addr_err)));
      S_LEV:   commit = out_free;
      S_MD:    commit = out_free && md_rsp.done;
      default: commit = 1'b0;
    endcase
  end

  always_comb begin
    re    = 1'b0;
    raddr = sp64;
    if (accept) begin
      re = 1'b1;
      if (action_i == OP_LEV) raddr = bp64;
      else if (action_i inside {OP_LI, OP_LC}) raddr = acc_q;
      else raddr = sp64;
    end else if ((state_q == S_EXEC) && !halted_q && (op_q == OP_LEV) && !lev_addr_err) begin
      re    = 1'b1;
      raddr = bp64 + 64'd8;
    end
  end

  assign wmask = wbyte ? (64'hFF << {waddr[2:0], 3'b000}) : '1;

  svm_ram #(
    .WIDTH(64),
    .DEPTH(MEM_WORDS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (commit && !halted_q && !halt_now && wr),
    .waddr_i (waddr[AW+2:3]),
    .wdata_i (wdata),
    .wmask_i (wmask),
    .re_i    (re),
    .raddr_i (raddr[AW+2:3]),
    .rdata_o (rd_data)
  );

  always_comb begin
    md_req.start = (state_q == S_EXEC) && !halted_q && need_md;
    md_req.x     = x;
    md_req.y     = acc_q;
    case (op_q)
      OP_MUL:  md_req.op = MD_MUL;
      OP_DIV:  md_req.op = MD_DIV;
      default: md_req.op = MD_MOD;
    endcase
  end

  svm_muldiv u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (md_req),
    .rsp_o  (md_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      acc_q       <= '0;
      sp_q        <= SW'(MEM_BYTES);
      bp_q        <= SW'(MEM_BYTES);
      pc_q        <= '0;
      halted_q    <= 1'b0;
      code_q      <= ST_RUN;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: if (accept) state_q <= S_EXEC;
        S_EXEC: begin
          if (commit) state_q <= S_IDLE;
          else if (!halted_q && need_md) state_q <= S_MD;
          else if (!halted_q && (op_q == OP_LEV) && !lev_addr_err) state_q <= S_LEV;
        end
        S_LEV, S_MD: if (commit) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
      if (commit) begin
        out_valid_q <= 1'b1;
        if (!halted_q && halt_now) begin
          halted_q <= 1'b1;
          code_q   <= (err != ST_RUN) ? err : ST_EXIT;
        end else if (!halted_q) begin
          acc_q <= a_n;
          sp_q  <= sp_n[SW-1:0];
          bp_q  <= bp_n[SW-1:0];
          pc_q  <= npc[PCW-1:0];
        end
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= action_i;
      opd_q <= operand_i;
    end
    if ((state_q == S_EXEC) && (op_q == OP_LEV)) t_q <= rd_data;
    if (commit) begin
      if (halted_q) begin
        out_acc_q    <= acc_q;
        out_pc_q     <= pc64[14:0];
        out_strobe_q <= 1'b0;
        out_status_q <= code_q;
      end else if (halt_now) begin
        out_acc_q    <= acc_q;
        out_pc_q     <= pc64[14:0];
        out_strobe_q <= 1'b0;
        out_status_q <= (err != ST_RUN) ? err : ST_EXIT;
      end else begin
        out_acc_q    <= a_n;
        out_pc_q     <= npc[14:0];
        out_strobe_q <= strobe;
        out_status_q <= ST_RUN;
      end
    end
  end

  assign in_stall_o     = (state_q != S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign acc_value_o    = out_acc_q;
  assign next_pc_o      = out_pc_q;
  assign print_strobe_o = out_strobe_q;
  assign status_o       = out_status_q;

  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |=> halted_q)
    else $error("halted state left without reset");

  a_no_write_halted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit && wr && !halt_now && !halted_q) |-> (state_q != S_IDLE))
    else $error("memory write outside execute");

  a_halt_reports: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(halted_q) |-> (out_valid_o && (status_o != ST_RUN)))
    else $error("halt without error status");

  a_md_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    md_req.start |=> (state_q == S_MD) && !md_rsp.done)
    else $error("divider started outside execute");

endmodule
